/* hdl/dusm_pkg.sv */
// Shared package for the DMX universe store and merge engine.
// Holds sizes, operation and register codes, channel and control types.
// Depends on nothing; other files use it by scoped names, the testbench by import.
package dusm_pkg;

   // Store geometry.
   localparam int SLOT_COUNT = 513;
   localparam int PORT_COUNT = 3;
   localparam int MEM_DEPTH  = PORT_COUNT * SLOT_COUNT;
   localparam int MEM_AW     = $clog2(MEM_DEPTH);
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int PIDX_W     = $clog2(PORT_COUNT);

   // Field widths.
   localparam int OP_W     = 3;
   localparam int PORT_W   = 2;
   localparam int INDEX_W  = 10;
   localparam int VALUE_W  = 8;
   localparam int TICK_W   = 32;
   localparam int MODE_W   = 2;
   localparam int MASK_W   = 3;
   localparam int SEL_W    = 6;
   localparam int SRC_W    = 2;

   // Configuration port.
   localparam int PADDR_W  = 5;
   localparam int PDATA_W  = 32;
   localparam int REG_IDX_W = 3;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
   localparam logic [OP_W-1:0] OP_MARK   = 3'd2;
   localparam logic [OP_W-1:0] OP_MERGE  = 3'd3;
   localparam logic [OP_W-1:0] OP_READ   = 3'd4;

   // Port roles.
   localparam logic [MODE_W-1:0] MODE_OUTPUT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INPUT  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MIRROR = 2'd2;
   localparam logic [MODE_W-1:0] MODE_MERGE  = 2'd3;

   // Register indexes (byte address / 4).
   localparam logic [REG_IDX_W-1:0] REG_PORT0_MODE   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PORT1_MODE   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_PORT2_MODE   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_LTP_MASK     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SOURCE_A_SEL = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_SOURCE_B_SEL = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [PORT_W-1:0]  port;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
      logic               restart;
      logic [TICK_W-1:0]  tick;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic [MODE_W-1:0] port0_mode;
      logic [MODE_W-1:0] port1_mode;
      logic [MODE_W-1:0] port2_mode;
      logic [MASK_W-1:0] ltp_mask;
      logic [SEL_W-1:0]  source_a_sel;
      logic [SEL_W-1:0]  source_b_sel;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              clear_step;
      logic              req_load;
      logic              exec;
      logic              slot_clear;
      logic              merge_step;
      logic              rsp_load;
      logic [PIDX_W-1:0] src_a;
      logic [PIDX_W-1:0] src_b;
      logic [PIDX_W-1:0] dst;
      logic [SRC_W-1:0]  stamp_a;
      logic [SRC_W-1:0]  stamp_b;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic            clear_last;
      logic            slot_last;
      logic            a_newer;
      logic [OP_W-1:0] op;
   } sts_type;

   // First store address of a universe.
   function automatic logic [MEM_AW-1:0] slot_base(input logic [PIDX_W-1:0] p);
      return MEM_AW'(p) * MEM_AW'(SLOT_COUNT);
   endfunction

endpackage

/* hdl/dusm_ram.sv */
// Generic single write, dual read RAM with registered read data.
// Stand-alone; used for the slot store of the merge engine.
module dusm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* hdl/dusm_ctrl.sv */
// Controller of the merge engine: clearing pass, request sequencing, merge pass.
// Depends on dusm_pkg; drives the datapath through cmd_type and reads sts_type.
module dusm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dusm_pkg::cfg_type cfg,
   input  dusm_pkg::sts_type sts,
   output dusm_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_EXEC   = 3'd2;
   localparam logic [2:0] ST_RDWAIT = 3'd3;
   localparam logic [2:0] ST_MSETUP = 3'd4;
   localparam logic [2:0] ST_MRUN   = 3'd5;
   localparam logic [2:0] ST_MNEXT  = 3'd6;

   logic [2:0]                     state_ff, state_in;
   logic [dusm_pkg::PIDX_W-1:0]    port_ff, port_in;

   logic [dusm_pkg::PORT_W-1:0]    pp;
   logic [dusm_pkg::MODE_W-1:0]    mode;
   logic [dusm_pkg::SRC_W-1:0]     sa, sb, pick;
   logic [dusm_pkg::SEL_W-1:0]     sa_bits, sb_bits;
   logic [dusm_pkg::MASK_W-1:0]    ltp_bits;
   logic                           sa_ok, sb_ok, active;
   logic [dusm_pkg::SRC_W-1:0]     use_a, use_b;

   // Role and sources of the universe currently visited by the merge pass.
   always_comb begin
      pp       = dusm_pkg::PORT_W'(port_ff);
      sa_bits  = cfg.source_a_sel >> (dusm_pkg::SRC_W * port_ff);
      sb_bits  = cfg.source_b_sel >> (dusm_pkg::SRC_W * port_ff);
      sa       = sa_bits[dusm_pkg::SRC_W-1:0];
      sb       = sb_bits[dusm_pkg::SRC_W-1:0];
      ltp_bits = cfg.ltp_mask >> port_ff;
      if (pp == dusm_pkg::PORT_W'(0)) begin
         mode = cfg.port0_mode;
      end else if (pp == dusm_pkg::PORT_W'(1)) begin
         mode = cfg.port1_mode;
      end else begin
         mode = cfg.port2_mode;
      end
      sa_ok  = sa < dusm_pkg::SRC_W'(dusm_pkg::PORT_COUNT);
      sb_ok  = sb < dusm_pkg::SRC_W'(dusm_pkg::PORT_COUNT);
      pick   = sts.a_newer ? sa : sb;
      active = 1'b0;
      use_a  = sa;
      use_b  = sb;
      case (mode)
         dusm_pkg::MODE_MIRROR: begin
            // A copy is a maximum of the source with itself.
            active = sa_ok && (sa != pp);
            use_b  = sa;
         end
         dusm_pkg::MODE_MERGE: begin
            active = (sa != sb) && sa_ok && sb_ok;
            if (ltp_bits[0]) begin
               use_a = pick;
               use_b = pick;
            end
         end
         default: begin
            active = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      port_in        = port_ff;
      cmd            = '0;
      cmd.src_a      = use_a[dusm_pkg::PIDX_W-1:0];
      cmd.src_b      = use_b[dusm_pkg::PIDX_W-1:0];
      cmd.dst        = port_ff;
      cmd.stamp_a    = sa;
      cmd.stamp_b    = sb;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.req_load = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            case (sts.op)
               dusm_pkg::OP_MERGE: begin
                  port_in  = '0;
                  state_in = ST_MSETUP;
               end
               dusm_pkg::OP_READ: begin
                  state_in = ST_RDWAIT;
               end
               default: begin
                  cmd.rsp_load = 1'b1;
                  state_in     = ST_IDLE;
               end
            endcase
         end
         ST_RDWAIT: begin
            cmd.rsp_load = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_MSETUP: begin
            if (active) begin
               cmd.slot_clear = 1'b1;
               state_in       = ST_MRUN;
            end else begin
               state_in = ST_MNEXT;
            end
         end
         ST_MRUN: begin
            cmd.merge_step = 1'b1;
            if (sts.slot_last) begin
               state_in = ST_MNEXT;
            end
         end
         ST_MNEXT: begin
            if (port_ff == dusm_pkg::PIDX_W'(dusm_pkg::PORT_COUNT - 1)) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               port_in  = port_ff + dusm_pkg::PIDX_W'(1);
               state_in = ST_MSETUP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         port_ff  <= '0;
      end else begin
         state_ff <= state_in;
         port_ff  <= port_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* hdl/dusm_dp.sv */
// Datapath of the merge engine: request register, slot store, pointers, stamps,
// merge pipeline and result register. Depends on dusm_pkg and dusm_ram.
module dusm_dp (
   input  logic              clock,
   input  logic              reset,
   input  dusm_pkg::req_type req_data,
   input  dusm_pkg::cmd_type cmd,
   output dusm_pkg::sts_type sts,
   output logic              rsp_valid,
   output dusm_pkg::rsp_type rsp_data
);

   dusm_pkg::req_type                req_ff;
   logic [dusm_pkg::MEM_AW-1:0]      clr_ff, clr_in;
   logic [dusm_pkg::SLOT_W-1:0]      slot_ff, slot_in;
   logic                             mwr_valid_ff;
   logic [dusm_pkg::MEM_AW-1:0]      mwr_addr_ff, mwr_addr_in;
   logic [dusm_pkg::INDEX_W-1:0]     ptr_ff [dusm_pkg::PORT_COUNT];
   logic [dusm_pkg::TICK_W-1:0]      stamp_ff [dusm_pkg::PORT_COUNT];
   logic                             rsp_valid_ff;
   dusm_pkg::rsp_type                rsp_ff, rsp_in;

   logic                             port_ok, chan_ok, ptr_ok, read_ok, status_now;
   logic [dusm_pkg::PIDX_W-1:0]      pidx;
   logic [dusm_pkg::MEM_AW-1:0]      base;
   logic [dusm_pkg::INDEX_W:0]       chan_slot;
   logic [dusm_pkg::INDEX_W-1:0]     ptr_cur, ptr_eff, ptr_in;
   logic                             ptr_wr, stamp_wr, req_wr;
   logic [dusm_pkg::MEM_AW-1:0]      req_addr;
   logic [dusm_pkg::TICK_W-1:0]      stamp_a, stamp_b;

   logic                             ram_wr_en;
   logic [dusm_pkg::MEM_AW-1:0]      ram_wr_addr, ram_rd_addr_a, ram_rd_addr_b;
   logic [dusm_pkg::VALUE_W-1:0]     ram_wr_data, ram_rd_a, ram_rd_b, slot_max;

   // Request decode.
   always_comb begin
      port_ok   = req_ff.port < dusm_pkg::PORT_W'(dusm_pkg::PORT_COUNT);
      pidx      = req_ff.port[dusm_pkg::PIDX_W-1:0];
      base      = dusm_pkg::slot_base(pidx);
      chan_slot = {1'b0, req_ff.index} + (dusm_pkg::INDEX_W + 1)'(1);
      chan_ok   = chan_slot < (dusm_pkg::INDEX_W + 1)'(dusm_pkg::SLOT_COUNT);
      ptr_cur   = port_ok ? ptr_ff[pidx] : '0;
      ptr_eff   = req_ff.restart ? dusm_pkg::INDEX_W'(1) : ptr_cur;
      ptr_ok    = ptr_eff < dusm_pkg::INDEX_W'(dusm_pkg::SLOT_COUNT);
      read_ok   = port_ok && (req_ff.index < dusm_pkg::INDEX_W'(dusm_pkg::SLOT_COUNT));
      ptr_in    = ptr_ok ? (ptr_eff + dusm_pkg::INDEX_W'(1)) : ptr_eff;
      status_now = 1'b0;
      req_wr     = 1'b0;
      ptr_wr     = 1'b0;
      stamp_wr   = 1'b0;
      req_addr   = base + dusm_pkg::MEM_AW'(chan_slot);
      case (req_ff.op)
         dusm_pkg::OP_WRITE: begin
            status_now = !(port_ok && chan_ok);
            req_wr     = port_ok && chan_ok;
         end
         dusm_pkg::OP_APPEND: begin
            // A restart still takes effect when the byte itself overflows.
            status_now = !(port_ok && ptr_ok);
            req_wr     = port_ok && ptr_ok;
            ptr_wr     = port_ok;
            req_addr   = base + dusm_pkg::MEM_AW'(ptr_eff);
         end
         dusm_pkg::OP_MARK: begin
            status_now = !port_ok;
            stamp_wr   = port_ok;
         end
         dusm_pkg::OP_MERGE: begin
            status_now = 1'b0;
         end
         dusm_pkg::OP_READ: begin
            status_now = !read_ok;
         end
         default: begin
            status_now = 1'b1;
         end
      endcase
   end

   // Source stamps for the latest-takes-precedence choice.
   always_comb begin
      stamp_a = '0;
      stamp_b = '0;
      if (cmd.stamp_a < dusm_pkg::SRC_W'(dusm_pkg::PORT_COUNT)) begin
         stamp_a = stamp_ff[cmd.stamp_a[dusm_pkg::PIDX_W-1:0]];
      end
      if (cmd.stamp_b < dusm_pkg::SRC_W'(dusm_pkg::PORT_COUNT)) begin
         stamp_b = stamp_ff[cmd.stamp_b[dusm_pkg::PIDX_W-1:0]];
      end
   end

   // Store ports: the clearing pass, the merge write-back and request writes
   // never overlap in time.
   always_comb begin
      slot_max      = (ram_rd_b > ram_rd_a) ? ram_rd_b : ram_rd_a;
      ram_rd_addr_a = cmd.merge_step ?
                      (dusm_pkg::slot_base(cmd.src_a) + dusm_pkg::MEM_AW'(slot_ff)) :
                      (base + dusm_pkg::MEM_AW'(req_ff.index));
      ram_rd_addr_b = dusm_pkg::slot_base(cmd.src_b) + dusm_pkg::MEM_AW'(slot_ff);
      mwr_addr_in   = dusm_pkg::slot_base(cmd.dst) + dusm_pkg::MEM_AW'(slot_ff);
      if (cmd.clear_step) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_data = '0;
      end else if (mwr_valid_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = mwr_addr_ff;
         ram_wr_data = slot_max;
      end else begin
         ram_wr_en   = cmd.exec && req_wr;
         ram_wr_addr = req_addr;
         ram_wr_data = req_ff.value;
      end
   end

   always_comb begin
      clr_in  = cmd.clear_step ? (clr_ff + dusm_pkg::MEM_AW'(1)) : clr_ff;
      slot_in = slot_ff;
      if (cmd.slot_clear) begin
         slot_in = '0;
      end else if (cmd.merge_step) begin
         slot_in = slot_ff + dusm_pkg::SLOT_W'(1);
      end
      rsp_in.status     = status_now;
      rsp_in.read_value = ((req_ff.op == dusm_pkg::OP_READ) && read_ok) ? ram_rd_a : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         mwr_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < dusm_pkg::PORT_COUNT; i++) begin
            ptr_ff[i]   <= dusm_pkg::INDEX_W'(1);
            stamp_ff[i] <= '0;
         end
      end else begin
         clr_ff       <= clr_in;
         mwr_valid_ff <= cmd.merge_step;
         rsp_valid_ff <= cmd.rsp_load;
         if (cmd.exec && ptr_wr) begin
            ptr_ff[pidx] <= ptr_in;
         end
         if (cmd.exec && stamp_wr) begin
            stamp_ff[pidx] <= req_ff.tick;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      mwr_addr_ff <= mwr_addr_in;
      if (cmd.req_load) begin
         req_ff <= req_data;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   dusm_ram #(
      .WIDTH (dusm_pkg::VALUE_W),
      .DEPTH (dusm_pkg::MEM_DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_addr_a (ram_rd_addr_a),
      .rd_data_a (ram_rd_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_b (ram_rd_b)
   );

   assign sts.clear_last = (clr_ff == dusm_pkg::MEM_AW'(dusm_pkg::MEM_DEPTH - 1));
   assign sts.slot_last  = (slot_ff == dusm_pkg::SLOT_W'(dusm_pkg::SLOT_COUNT - 1));
   assign sts.a_newer    = stamp_a > stamp_b;
   assign sts.op         = req_ff.op;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hdl/dmx_universe_store_merge_top.sv */
// Top level of the DMX universe store and merge engine.
// Holds the configuration registers; depends on dusm_pkg, dusm_ctrl and dusm_dp.
//
//  Channel        Ports                                   Direction  Handshake
//  -------------  --------------------------------------  ---------  --------------------
//  request        start, busy, req_data                   in         start && !busy
//  result         rsp_valid, rsp_data                     out        one-cycle strobe
//  configuration  psel, penable, pwrite, paddr, pwdata,   in/out     APB, pready always 1
//                 prdata, pready
//
// After reset a clearing pass zeroes the slot store, one slot per cycle, with busy high;
// configuration works meanwhile. Write, append, frame mark and unknown ops are answered
// from the execute state; a slot read first waits for the store's registered read data.
// A merge pass visits every port in a setup and a next state; a port that mirrors or merges
// from usable sources sends one slot per cycle through the store's single write port.
// The result strobe cannot be stalled; the next request may be accepted in its cycle.
module dmx_universe_store_merge_top (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel.
   input  logic                           start,
   output logic                           busy,
   input  dusm_pkg::req_type              req_data,
   // Result channel.
   output logic                           rsp_valid,
   output dusm_pkg::rsp_type              rsp_data,
   // Configuration port.
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [dusm_pkg::PADDR_W-1:0]   paddr,
   input  logic [dusm_pkg::PDATA_W-1:0]   pwdata,
   output logic [dusm_pkg::PDATA_W-1:0]   prdata,
   output logic                           pready
);

   dusm_pkg::cfg_type                 cfg_ff, cfg_in;
   dusm_pkg::cmd_type                 cmd;
   dusm_pkg::sts_type                 sts;
   logic                              csr_write;
   logic [dusm_pkg::REG_IDX_W-1:0]    csr_idx;

   // Registers sit on word addresses; the two low address bits are ignored.
   assign csr_idx   = paddr[dusm_pkg::PADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_idx)
            dusm_pkg::REG_PORT0_MODE: begin
               cfg_in.port0_mode = pwdata[dusm_pkg::MODE_W-1:0];
            end
            dusm_pkg::REG_PORT1_MODE: begin
               cfg_in.port1_mode = pwdata[dusm_pkg::MODE_W-1:0];
            end
            dusm_pkg::REG_PORT2_MODE: begin
               cfg_in.port2_mode = pwdata[dusm_pkg::MODE_W-1:0];
            end
            dusm_pkg::REG_LTP_MASK: begin
               cfg_in.ltp_mask = pwdata[dusm_pkg::MASK_W-1:0];
            end
            dusm_pkg::REG_SOURCE_A_SEL: begin
               cfg_in.source_a_sel = pwdata[dusm_pkg::SEL_W-1:0];
            end
            dusm_pkg::REG_SOURCE_B_SEL: begin
               cfg_in.source_b_sel = pwdata[dusm_pkg::SEL_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // Read-back of the registers; unused addresses read as zero.
   always_comb begin
      case (csr_idx)
         dusm_pkg::REG_PORT0_MODE:   prdata = dusm_pkg::PDATA_W'(cfg_ff.port0_mode);
         dusm_pkg::REG_PORT1_MODE:   prdata = dusm_pkg::PDATA_W'(cfg_ff.port1_mode);
         dusm_pkg::REG_PORT2_MODE:   prdata = dusm_pkg::PDATA_W'(cfg_ff.port2_mode);
         dusm_pkg::REG_LTP_MASK:     prdata = dusm_pkg::PDATA_W'(cfg_ff.ltp_mask);
         dusm_pkg::REG_SOURCE_A_SEL: prdata = dusm_pkg::PDATA_W'(cfg_ff.source_a_sel);
         dusm_pkg::REG_SOURCE_B_SEL: prdata = dusm_pkg::PDATA_W'(cfg_ff.source_b_sel);
         default:                    prdata = '0;
      endcase
   end

   // Reset: all ports are outputs, highest-takes-precedence, no sources selected.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.port0_mode   <= dusm_pkg::MODE_OUTPUT;
         cfg_ff.port1_mode   <= dusm_pkg::MODE_OUTPUT;
         cfg_ff.port2_mode   <= dusm_pkg::MODE_OUTPUT;
         cfg_ff.ltp_mask     <= '0;
         cfg_ff.source_a_sel <= '1;
         cfg_ff.source_b_sel <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The controller sequences every request and the merge pass; the datapath holds
   // the slot store, append pointers, frame stamps and the result register.
   dusm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cfg   (cfg_ff),
      .sts   (sts),
      .cmd   (cmd)
   );

   dusm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for dmx_universe_store_merge_top, the DMX universe store and merge engine.
// Predicts every result with its own model of the slot store; depends on dusm_pkg and the RTL.
module testbench;
   import dusm_pkg::*;

   localparam int HALF_PERIOD    = 2;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int REPORT_LIMIT   = 10;
   localparam int SETTLE_CYCLES  = 20;
   localparam int PHASES         = 6;
   localparam int PHASE_REQUESTS = 160;

   // Codes the package does not name.
   localparam logic [OP_W-1:0]   UNUSED_OP_FIRST = 3'd5;
   localparam logic [OP_W-1:0]   UNUSED_OP_LAST  = 3'd7;
   localparam logic [SRC_W-1:0]  SOURCE_NONE     = 2'd3;
   localparam logic [PORT_W-1:0] PORT_ABSENT     = 2'd3;
   localparam logic              STATUS_DONE     = 1'b0;
   localparam logic              STATUS_REJECTED = 1'b1;
   localparam int                INDEX_MAX       = (1 << INDEX_W) - 1;

   // Every input of the block starts from a known value.
   logic               clock   = 1'b0;
   logic               reset   = 1'b1;
   logic               start   = 1'b0;
   logic               busy;
   req_type            req_data = '0;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               psel    = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite  = 1'b0;
   logic [PADDR_W-1:0] paddr   = '0;
   logic [PDATA_W-1:0] pwdata  = '0;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   // Predicted state of the block: slot levels, frame stamps, append pointers and
   // the register file, kept masked to each register's width.
   logic [VALUE_W-1:0] slot_level [PORT_COUNT][SLOT_COUNT];
   logic [TICK_W-1:0]  frame_stamp [PORT_COUNT];
   logic [INDEX_W-1:0] append_ptr [PORT_COUNT];
   logic [PDATA_W-1:0] csr_copy [0:REG_SOURCE_B_SEL];

   // Results still owed by the block, oldest first.
   rsp_type     owed_results [$];
   int unsigned failures     = 0;
   int unsigned stall_cycles = 0;
   bit          gaps_on      = 1'b1;

   dmx_universe_store_merge_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial forever #HALF_PERIOD clock = ~clock;

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("mismatch at %0t ns: %s", $time, msg);
   endfunction

   // Ports are visited in order, so a later port sees what earlier ports just wrote.
   function automatic void run_merge_pass();
      logic [SRC_W-1:0]  src_a;
      logic [SRC_W-1:0]  src_b;
      logic [SRC_W-1:0]  newest;
      logic [MODE_W-1:0] role;
      for (int p = 0; p < PORT_COUNT; p++) begin
         role  = csr_copy[REG_PORT0_MODE + p][MODE_W-1:0];
         src_a = csr_copy[REG_SOURCE_A_SEL][SRC_W*p +: SRC_W];
         src_b = csr_copy[REG_SOURCE_B_SEL][SRC_W*p +: SRC_W];
         if (role == MODE_MIRROR) begin
            if (src_a < PORT_COUNT && src_a != p)
               for (int j = 0; j < SLOT_COUNT; j++) slot_level[p][j] = slot_level[src_a][j];
         end else if (role == MODE_MERGE && src_a != src_b
                      && src_a < PORT_COUNT && src_b < PORT_COUNT) begin
            if (csr_copy[REG_LTP_MASK][p]) begin
               // Source a wins only with a strictly newer stamp.
               newest = (frame_stamp[src_a] > frame_stamp[src_b]) ? src_a : src_b;
               for (int j = 0; j < SLOT_COUNT; j++) slot_level[p][j] = slot_level[newest][j];
            end else begin
               for (int j = 0; j < SLOT_COUNT; j++)
                  slot_level[p][j] = (slot_level[src_b][j] > slot_level[src_a][j]) ?
                                     slot_level[src_b][j] : slot_level[src_a][j];
            end
         end
      end
   endfunction

   // Applies one accepted request to the predicted state and returns its result.
   function automatic rsp_type apply_request(input req_type r);
      rsp_type res;
      logic    port_ok;
      res        = '0;
      res.status = STATUS_DONE;
      port_ok    = r.port < PORT_COUNT;
      case (r.op)
         OP_WRITE: begin
            if (!port_ok || r.index >= SLOT_COUNT - 1) res.status = STATUS_REJECTED;
            else slot_level[r.port][r.index + 1] = r.value;
         end
         OP_APPEND: begin
            if (!port_ok) begin
               res.status = STATUS_REJECTED;
            end else begin
               if (r.restart) append_ptr[r.port] = INDEX_W'(1);
               if (append_ptr[r.port] >= SLOT_COUNT) begin
                  res.status = STATUS_REJECTED;
               end else begin
                  slot_level[r.port][append_ptr[r.port]] = r.value;
                  append_ptr[r.port] = append_ptr[r.port] + 1'b1;
               end
            end
         end
         OP_MARK: begin
            if (!port_ok) res.status = STATUS_REJECTED;
            else frame_stamp[r.port] = r.tick;
         end
         OP_MERGE: run_merge_pass();
         OP_READ: begin
            if (!port_ok || r.index >= SLOT_COUNT) res.status = STATUS_REJECTED;
            else res.read_value = slot_level[r.port][r.index];
         end
         default: res.status = STATUS_REJECTED;
      endcase
      return res;
   endfunction

   function automatic req_type compose(input logic [OP_W-1:0] op, input logic [PORT_W-1:0] port,
                                       input logic [INDEX_W-1:0] index,
                                       input logic [VALUE_W-1:0] value, input logic restart,
                                       input logic [TICK_W-1:0] tick);
      req_type r;
      r.op      = op;
      r.port    = port;
      r.index   = index;
      r.value   = value;
      r.restart = restart;
      r.tick    = tick;
      return r;
   endfunction

   function automatic logic [SEL_W-1:0] sources(input logic [SRC_W-1:0] s0, s1, s2);
      return {s2, s1, s0};
   endfunction

   // Random request. Indexes stay mostly among the first channels so that reads find
   // what writes and merges left there; the full range, the absent port, restarts,
   // reserved op codes and colliding stamps come in now and then.
   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)      r.op = OP_WRITE;
      else if (pick < 45) r.op = OP_APPEND;
      else if (pick < 55) r.op = OP_MARK;
      else if (pick < 59) r.op = OP_MERGE;
      else if (pick < 97) r.op = OP_READ;
      else                r.op = OP_W'($urandom_range(UNUSED_OP_FIRST, UNUSED_OP_LAST));
      r.port    = ($urandom_range(0, 19) == 0) ? PORT_ABSENT
                                               : PORT_W'($urandom_range(0, PORT_COUNT - 1));
      r.index   = ($urandom_range(0, 9) == 0) ? INDEX_W'($urandom_range(0, INDEX_MAX))
                                              : INDEX_W'($urandom_range(0, 24));
      r.value   = VALUE_W'($urandom_range(0, 255));
      r.restart = ($urandom_range(0, 7) == 0);
      r.tick    = ($urandom_range(0, 3) == 0) ? TICK_W'($urandom_range(0, 2)) : $urandom;
      return r;
   endfunction

   // Sends one request and waits until the block takes it. start stays high on return
   // so that the next request can follow without a gap; every path that stops sending
   // lowers it in the same step as the acceptance.
   task automatic send_request(input req_type r);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      owed_results.push_back(apply_request(r));
   endtask

   task automatic wait_until_idle();
      start <= 1'b0;
      do @(posedge clock); while (owed_results.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   // One register access: an optional write, always followed by a read-back that is
   // checked against the predicted register file, then the bus is left idle.
   task automatic access_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [PDATA_W-1:0] val, input bit do_write);
      logic [PDATA_W-1:0] width_mask;
      case (idx)
         REG_LTP_MASK:                       width_mask = (1 << MASK_W) - 1;
         REG_SOURCE_A_SEL, REG_SOURCE_B_SEL: width_mask = (1 << SEL_W) - 1;
         default:                            width_mask = (1 << MODE_W) - 1;
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= do_write;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      if (do_write) begin
         @(posedge clock);
         penable <= 1'b1;
         @(posedge clock);
         penable <= 1'b0;
         pwrite  <= 1'b0;
         csr_copy[idx] = val & width_mask;
      end
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (prdata !== csr_copy[idx])
         note_failure($sformatf("register %0d read exp %08h got %08h", idx, csr_copy[idx], prdata));
      @(posedge clock);
   endtask

   task automatic configure(input logic [MODE_W-1:0] m0, m1, m2, input logic [MASK_W-1:0] ltp,
                            input logic [SEL_W-1:0] sel_a, sel_b);
      wait_until_idle();
      access_register(REG_PORT0_MODE, PDATA_W'(m0), 1'b1);
      access_register(REG_PORT1_MODE, PDATA_W'(m1), 1'b1);
      access_register(REG_PORT2_MODE, PDATA_W'(m2), 1'b1);
      access_register(REG_LTP_MASK, PDATA_W'(ltp), 1'b1);
      access_register(REG_SOURCE_A_SEL, PDATA_W'(sel_a), 1'b1);
      access_register(REG_SOURCE_B_SEL, PDATA_W'(sel_b), 1'b1);
   endtask

   // Result checker. The block cannot be held off, so every strobe is taken and
   // compared with the oldest owed result, field by field.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (owed_results.size() == 0) begin
            note_failure($sformatf("unexpected result read_value %02h status %0d",
                                   rsp_data.read_value, rsp_data.status));
         end else begin
            want = owed_results.pop_front();
            if (rsp_data.read_value !== want.read_value || rsp_data.status !== want.status)
               note_failure($sformatf("read_value exp %02h got %02h, status exp %0d got %0d",
                                      want.read_value, rsp_data.read_value,
                                      want.status, rsp_data.status));
         end
      end
   end

   // Watchdog: a merge pass or the clearing pass after reset keeps the block quiet while it
   // walks the slot store, so only a silence that reaches WATCHDOG_LIMIT means it has hung.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Register reset values, then reads of a cleared store at both ends of the slots.
   // These requests wait out the clearing pass that follows reset.
   task automatic test_reset_state();
      for (int i = REG_PORT0_MODE; i <= REG_SOURCE_B_SEL; i++)
         access_register(REG_IDX_W'(i), '0, 1'b0);
      send_request(compose(OP_READ, 2'd0, '0, 8'h5c, 1'b1, $urandom));
      send_request(compose(OP_READ, 2'd2, INDEX_W'(SLOT_COUNT - 1), 8'ha3, 1'b0, $urandom));
   endtask

   // Channel writes land one slot above the channel number, so the last channel is the
   // last slot and the next one is already past the end.
   task automatic test_channel_writes();
      send_request(compose(OP_WRITE, 2'd0, '0, 8'hff, 1'b0, $urandom));
      send_request(compose(OP_WRITE, 2'd2, INDEX_W'(SLOT_COUNT - 2), 8'h5a, 1'b1, $urandom));
      send_request(compose(OP_WRITE, 2'd1, 10'd3, 8'h00, 1'b0, $urandom));
      send_request(compose(OP_WRITE, 2'd1, INDEX_W'(SLOT_COUNT - 1), 8'h77, 1'b0, $urandom));
      send_request(compose(OP_WRITE, 2'd1, INDEX_W'(INDEX_MAX), 8'h33, 1'b1, $urandom));
      send_request(compose(OP_WRITE, PORT_ABSENT, 10'd5, 8'h44, 1'b0, $urandom));
      send_request(compose(OP_READ, 2'd0, 10'd1, 8'h00, 1'b0, $urandom));
      send_request(compose(OP_READ, 2'd2, INDEX_W'(SLOT_COUNT - 1), 8'hff, 1'b0, $urandom));
      send_request(compose(OP_READ, 2'd1, INDEX_W'(SLOT_COUNT), 8'h00, 1'b0, $urandom));
      send_request(compose(OP_READ, 2'd1, INDEX_W'(INDEX_MAX), 8'h00, 1'b1, $urandom));
      send_request(compose(OP_READ, PORT_ABSENT, 10'd1, 8'h00, 1'b0, $urandom));
   endtask

   task automatic test_stream_appends();
      send_request(compose(OP_APPEND, 2'd1, 10'd700, 8'h11, 1'b0, $urandom));
      send_request(compose(OP_APPEND, 2'd1, '0, 8'h22, 1'b0, $urandom));
      send_request(compose(OP_APPEND, 2'd1, 10'd9, 8'h33, 1'b1, $urandom));
      send_request(compose(OP_APPEND, PORT_ABSENT, '0, 8'h44, 1'b1, $urandom));
      send_request(compose(OP_READ, 2'd1, 10'd1, 8'h00, 1'b0, $urandom));
      send_request(compose(OP_READ, 2'd1, 10'd2, 8'h00, 1'b0, $urandom));
   endtask

   task automatic test_frame_marks();
      send_request(compose(OP_MARK, 2'd0, 10'd12, 8'h01, 1'b1, 32'hffff_ffff));
      send_request(compose(OP_MARK, 2'd1, '0, 8'h02, 1'b0, 32'h0000_0000));
      send_request(compose(OP_MARK, 2'd2, 10'd512, 8'h03, 1'b0, $urandom));
      send_request(compose(OP_MARK, PORT_ABSENT, '0, 8'h04, 1'b0, $urandom));
   endtask

   task automatic test_unknown_ops();
      for (int op = UNUSED_OP_FIRST; op <= UNUSED_OP_LAST; op++)
         send_request(compose(OP_W'(op), PORT_W'($urandom_range(0, PORT_COUNT - 1)),
                              INDEX_W'($urandom_range(0, 24)), VALUE_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), $urandom));
   endtask

   // Fresh levels in the first channels, a merge pass, and reads of what it left.
   task automatic scatter_and_merge();
      repeat (6)
         send_request(compose(OP_WRITE, PORT_W'($urandom_range(0, PORT_COUNT - 1)),
                              INDEX_W'($urandom_range(0, 7)), VALUE_W'($urandom_range(0, 255)),
                              1'b0, $urandom));
      send_request(compose(OP_MERGE, PORT_W'($urandom_range(0, 3)), INDEX_W'($urandom),
                           VALUE_W'($urandom), 1'($urandom_range(0, 1)), $urandom));
      repeat (4)
         send_request(compose(OP_READ, PORT_W'($urandom_range(0, PORT_COUNT - 1)),
                              INDEX_W'($urandom_range(0, 8)), 8'h00, 1'b0, $urandom));
   endtask

   task automatic test_merge_modes();
      logic [TICK_W-1:0] stamp;
      // Mirror of port 0 into port 1, then port 2 takes the highest of port 1 and itself.
      configure(MODE_INPUT, MODE_MIRROR, MODE_MERGE, '0,
                sources(SOURCE_NONE, 2'd0, 2'd1), sources(SOURCE_NONE, SOURCE_NONE, 2'd2));
      scatter_and_merge();
      // Latest takes precedence everywhere. Port 1 mirrors itself and port 2 names the same
      // source twice, so both are left alone; port 0 follows the newer of ports 1 and 2.
      configure(MODE_MERGE, MODE_MIRROR, MODE_MERGE, '1,
                sources(2'd1, 2'd1, 2'd0), sources(2'd2, SOURCE_NONE, 2'd0));
      scatter_and_merge();
      // Equal stamps hand the slots to source b, a strictly newer one to source a.
      stamp = $urandom;
      send_request(compose(OP_MARK, 2'd1, '0, 8'h00, 1'b0, stamp));
      send_request(compose(OP_MARK, 2'd2, '0, 8'h00, 1'b0, stamp));
      scatter_and_merge();
      send_request(compose(OP_MARK, 2'd1, '0, 8'h00, 1'b0, stamp + 1));
      scatter_and_merge();
      // Selects at both extremes: no usable source anywhere, nothing may change.
      configure(MODE_OUTPUT, MODE_MIRROR, MODE_MERGE, '0, '1, '0);
      scatter_and_merge();
      configure(MODE_MERGE, MODE_MERGE, MODE_MERGE, '0, '0, '1);
      scatter_and_merge();
   endtask

   // One stream fills a universe from slot 1 to the last slot; the bytes after that are
   // refused until a restart brings the pointer back to slot 1.
   task automatic test_append_overflow();
      logic [PORT_W-1:0] port_sel;
      port_sel = PORT_W'($urandom_range(0, PORT_COUNT - 1));
      send_request(compose(OP_APPEND, port_sel, INDEX_W'($urandom),
                           VALUE_W'($urandom_range(0, 255)), 1'b1, $urandom));
      for (int n = 2; n < SLOT_COUNT + 3; n++) begin
         send_request(compose(OP_APPEND, port_sel, INDEX_W'($urandom),
                              VALUE_W'($urandom_range(0, 255)), 1'b0, $urandom));
         if ($urandom_range(0, 31) == 0)
            send_request(compose(OP_READ, port_sel, INDEX_W'($urandom_range(0, SLOT_COUNT - 1)),
                                 8'h00, 1'b0, $urandom));
      end
      send_request(compose(OP_READ, port_sel, INDEX_W'(SLOT_COUNT - 1), 8'h00, 1'b0, $urandom));
      send_request(compose(OP_APPEND, port_sel, '0, VALUE_W'($urandom_range(0, 255)), 1'b1,
                           $urandom));
      send_request(compose(OP_READ, port_sel, 10'd1, 8'h00, 1'b0, $urandom));
   endtask

   // Random traffic under several register settings. The first phase mirrors port 0
   // everywhere with every port on latest-takes-precedence, the last runs a fixed
   // highest-takes-precedence chain without any sender gaps, the rest are drawn at random.
   task automatic test_random_phases();
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == 0)
            configure(MODE_MIRROR, MODE_MIRROR, MODE_MIRROR, '1, '0, '1);
         else if (ph == PHASES - 1)
            configure(MODE_OUTPUT, MODE_MERGE, MODE_MERGE, '0,
                      sources(SOURCE_NONE, 2'd0, 2'd1), sources(SOURCE_NONE, 2'd2, 2'd0));
         else
            configure(MODE_W'($urandom_range(0, 3)), MODE_W'($urandom_range(0, 3)),
                      MODE_W'($urandom_range(0, 3)), MASK_W'($urandom_range(0, 7)),
                      SEL_W'($urandom_range(0, 63)), SEL_W'($urandom_range(0, 63)));
         gaps_on = (ph != PHASES - 1);
         repeat (PHASE_REQUESTS) send_request(random_request());
      end
   endtask

   initial begin
      // The predicted state starts from the reset values of the block.
      for (int p = 0; p < PORT_COUNT; p++) begin
         for (int j = 0; j < SLOT_COUNT; j++) slot_level[p][j] = '0;
         frame_stamp[p] = '0;
         append_ptr[p]  = INDEX_W'(1);
      end
      for (int i = REG_PORT0_MODE; i <= REG_SOURCE_B_SEL; i++) csr_copy[i] = '0;
      csr_copy[REG_SOURCE_A_SEL] = (1 << SEL_W) - 1;
      csr_copy[REG_SOURCE_B_SEL] = (1 << SEL_W) - 1;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_channel_writes();
      test_stream_appends();
      test_frame_marks();
      test_unknown_ops();
      test_merge_modes();
      test_append_overflow();
      test_random_phases();

      // Every request is in; let the owed results arrive, then watch a little longer
      // for any stray strobe.
      wait_until_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
